/* hdl/olac_pkg.sv */
// Shared types, constants and helper functions for the one-link adaptive controller.
// Holds the item structs, the microcode ROM, the CORDIC angle table and saturation.
// No dependencies.
`timescale 1ns / 1ps

package olac_pkg;

  // Accumulator width: three 64-bit scaled products summed with headroom
  localparam int ACC_W = 66;
  localparam int CFG_IDX_W = 4;
  localparam int UC_PC_W = 6;
  localparam logic [UC_PC_W-1:0] UC_LAST = 6'd32;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_ITER_W = 5;
  localparam int CORDIC_W = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [31:0] INV_TWO_PI_Q32 = 32'sd683565276;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -66'sd2147483648;

  // Input item
  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] angle_rate;
    logic signed [31:0] target_angle;
    logic signed [31:0] target_rate;
    logic signed [31:0] target_accel;
  } ctrl_in_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] torque;
    logic signed [31:0] angle_error;
    logic signed [31:0] rate_error;
    logic signed [31:0] estimate_inertia;
    logic signed [31:0] estimate_gravity;
  } ctrl_out_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAMBDA   = 4'd0,
    CFG_FEEDBACK = 4'd1,
    CFG_G00      = 4'd2,
    CFG_G01      = 4'd3,
    CFG_G10      = 4'd4,
    CFG_G11      = 4'd5,
    CFG_DT       = 4'd6,
    CFG_GEAR     = 4'd7
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } olac_state_e;

  // Operand sources of the datapath
  typedef enum logic [4:0] {
    SRC_ZERO,
    SRC_ANGLE,
    SRC_RATE,
    SRC_TANGLE,
    SRC_TRATE,
    SRC_TACCEL,
    SRC_INV2PI,
    SRC_LAMBDA,
    SRC_KFB,
    SRC_G00,
    SRC_G01,
    SRC_G10,
    SRC_G11,
    SRC_DT,
    SRC_GEAR,
    SRC_E,
    SRC_DE,
    SRC_A,
    SRC_R,
    SRC_COS,
    SRC_T0,
    SRC_T1,
    SRC_F0,
    SRC_F1,
    SRC_P0,
    SRC_P1,
    SRC_S
  } src_e;

  // Accumulator operations; PSAT uses the saturated scaled product, PRAW the exact one
  typedef enum logic [2:0] {
    ACC_NOP,
    ACC_LD_SRC,
    ACC_SUB_SRC,
    ACC_LD_PSAT,
    ACC_ADD_PSAT,
    ACC_SUB_PSAT,
    ACC_LD_PRAW,
    ACC_ADD_PRAW
  } acc_op_e;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_E,
    DST_DE,
    DST_A,
    DST_R,
    DST_T0,
    DST_T1,
    DST_F0,
    DST_F1,
    DST_P0,
    DST_P1,
    DST_S
  } dst_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_CORDIC_START,
    SEQ_WAIT_COS,
    SEQ_FINISH
  } seq_e;

  // One control word
  typedef struct packed {
    seq_e    seq;
    logic    mul_en;
    src_e    mul_a;
    src_e    mul_b;
    acc_op_e acc_op;
    src_e    acc_src;
    dst_e    dst;
    logic    wr_neg;
  } uword_t;

  localparam uword_t UW_NOP = '{
    seq: SEQ_NEXT, mul_en: 1'b0, mul_a: SRC_ZERO, mul_b: SRC_ZERO,
    acc_op: ACC_NOP, acc_src: SRC_ZERO, dst: DST_NONE, wr_neg: 1'b0
  };

  // Saturate an accumulator value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // CORDIC rotation angles as fractions of a turn (2^32 per turn)
  function automatic logic [31:0] atan_turn(input logic [CORDIC_ITER_W-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051D;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2F9;
      5'd15:   a = 32'h0000517C;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A2F;
      5'd19:   a = 32'h00000517;
      5'd20:   a = 32'h0000028B;
      5'd21:   a = 32'h00000145;
      5'd22:   a = 32'h000000A2;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // Microcode ROM. A product issued in one step is read in a later step;
  // a register written from the accumulator is readable in the next step.
  function automatic uword_t ucode(input logic [UC_PC_W-1:0] pc);
    uword_t w;
    w = UW_NOP;
    case (pc)
      // phase multiply; e = angle - target_angle
      6'd0: begin
        w.mul_en = 1'b1; w.mul_a = SRC_ANGLE; w.mul_b = SRC_INV2PI;
        w.acc_op = ACC_LD_SRC; w.acc_src = SRC_ANGLE;
      end
      6'd1: begin
        w.seq = SEQ_CORDIC_START;
        w.acc_op = ACC_SUB_SRC; w.acc_src = SRC_TANGLE;
      end
      6'd2: begin
        w.dst = DST_E;
        w.acc_op = ACC_LD_SRC; w.acc_src = SRC_RATE;
      end
      6'd3: begin
        w.acc_op = ACC_SUB_SRC; w.acc_src = SRC_TRATE;
      end
      6'd4: w.dst = DST_DE;
      // a = target_accel - lambda*de
      6'd5: begin
        w.mul_en = 1'b1; w.mul_a = SRC_LAMBDA; w.mul_b = SRC_DE;
        w.acc_op = ACC_LD_SRC; w.acc_src = SRC_TACCEL;
      end
      6'd6: begin
        w.acc_op = ACC_SUB_PSAT;
        w.mul_en = 1'b1; w.mul_a = SRC_LAMBDA; w.mul_b = SRC_E;
      end
      // r = de + lambda*e
      6'd7: begin
        w.dst = DST_A;
        w.acc_op = ACC_LD_SRC; w.acc_src = SRC_DE;
      end
      6'd8: w.acc_op = ACC_ADD_PSAT;
      6'd9: w.dst = DST_R;
      // t0 = a*r
      6'd10: begin
        w.mul_en = 1'b1; w.mul_a = SRC_A; w.mul_b = SRC_R;
      end
      6'd11: w.acc_op = ACC_LD_PSAT;
      6'd12: w.dst = DST_T0;
      6'd13: w.seq = SEQ_WAIT_COS;
      // t1 = cos*r
      6'd14: begin
        w.mul_en = 1'b1; w.mul_a = SRC_COS; w.mul_b = SRC_R;
      end
      6'd15: w.acc_op = ACC_LD_PSAT;
      // f0 = -(g00*t0 + g01*t1), f1 = -(g10*t0 + g11*t1)
      6'd16: begin
        w.dst = DST_T1;
        w.mul_en = 1'b1; w.mul_a = SRC_G00; w.mul_b = SRC_T0;
      end
      6'd17: begin
        w.mul_en = 1'b1; w.mul_a = SRC_G01; w.mul_b = SRC_T1;
        w.acc_op = ACC_LD_PRAW;
      end
      6'd18: begin
        w.acc_op = ACC_ADD_PRAW;
        w.mul_en = 1'b1; w.mul_a = SRC_G10; w.mul_b = SRC_T0;
      end
      6'd19: begin
        w.dst = DST_F0; w.wr_neg = 1'b1;
        w.acc_op = ACC_LD_PRAW;
        w.mul_en = 1'b1; w.mul_a = SRC_G11; w.mul_b = SRC_T1;
      end
      6'd20: begin
        w.acc_op = ACC_ADD_PRAW;
        w.mul_en = 1'b1; w.mul_a = SRC_F0; w.mul_b = SRC_DT;
      end
      // p += f*dt
      6'd21: begin
        w.dst = DST_F1; w.wr_neg = 1'b1;
        w.acc_op = ACC_LD_SRC; w.acc_src = SRC_P0;
      end
      6'd22: begin
        w.acc_op = ACC_ADD_PSAT;
        w.mul_en = 1'b1; w.mul_a = SRC_F1; w.mul_b = SRC_DT;
      end
      6'd23: begin
        w.dst = DST_P0;
        w.acc_op = ACC_LD_SRC; w.acc_src = SRC_P1;
      end
      6'd24: w.acc_op = ACC_ADD_PSAT;
      // s = a*p0 + cos*p1 + k*r
      6'd25: begin
        w.dst = DST_P1;
        w.mul_en = 1'b1; w.mul_a = SRC_A; w.mul_b = SRC_P0;
      end
      6'd26: begin
        w.acc_op = ACC_LD_PRAW;
        w.mul_en = 1'b1; w.mul_a = SRC_COS; w.mul_b = SRC_P1;
      end
      6'd27: begin
        w.acc_op = ACC_ADD_PRAW;
        w.mul_en = 1'b1; w.mul_a = SRC_KFB; w.mul_b = SRC_R;
      end
      6'd28: w.acc_op = ACC_ADD_PRAW;
      6'd29: w.dst = DST_S;
      // torque = gear*s
      6'd30: begin
        w.mul_en = 1'b1; w.mul_a = SRC_GEAR; w.mul_b = SRC_S;
      end
      6'd31: w.acc_op = ACC_LD_PSAT;
      6'd32: w.seq = SEQ_FINISH;
      default: w.seq = SEQ_FINISH;
    endcase
    return w;
  endfunction

endpackage

/* hdl/one_link_adaptive_controller.sv */
// Top level of the one-link adaptive controller: microcode sequencer, shared
// multiplier and accumulator datapath, iterative CORDIC cosine, config registers.
// Depends on olac_pkg.
//
// Usage:
//  - in channel (in_valid_i/in_ready_o, in_data_i) takes one control tick item:
//    measured angle and rate, desired angle, rate and acceleration.
//  - out channel (out_valid_o/out_ready_i, out_data_o) returns torque, angle
//    and rate errors and the two updated parameter estimates, one per tick.
//  - cfg channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) writes the
//    gain registers; always ready, writes to unknown indexes are dropped.
//  - Each item runs the 33-step microprogram on the one shared 32x32
//    multiplier, and the sequencer holds on step 13 until the 24-iteration
//    CORDIC loop started on step 1 is done. One item at a time; the next
//    item is taken only after the result has gone to the output register.
//  - The result sits in an output register; a new item is taken while it
//    waits. If the receiver still stalls when the next result is ready, the
//    sequencer holds on its last step until the output register is free.
//  - Reset clears the estimates to zero and loads the register defaults.
`timescale 1ns / 1ps

module one_link_adaptive_controller #(
  parameter int FRAC_BITS = 16,
  parameter int COS_TABLE_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  olac_pkg::ctrl_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output olac_pkg::ctrl_out_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [olac_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);

  localparam int ACC_W = olac_pkg::ACC_W;
  localparam int CW = olac_pkg::CORDIC_W;
  localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - COS_TABLE_BITS)) - 32'd1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [30:0]        lambda_q, kfb_q, dt_q;
  logic signed [31:0] g00_q, g01_q, g10_q, g11_q, gear_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q <= 31'd65536;
      kfb_q    <= 31'd65536;
      g00_q    <= 32'sd65536;
      g01_q    <= 32'sd0;
      g10_q    <= 32'sd0;
      g11_q    <= 32'sd65536;
      dt_q     <= 31'd66;
      gear_q   <= 32'sd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        olac_pkg::CFG_LAMBDA:   lambda_q <= cfg_data_i[30:0];
        olac_pkg::CFG_FEEDBACK: kfb_q    <= cfg_data_i[30:0];
        olac_pkg::CFG_G00:      g00_q    <= cfg_data_i;
        olac_pkg::CFG_G01:      g01_q    <= cfg_data_i;
        olac_pkg::CFG_G10:      g10_q    <= cfg_data_i;
        olac_pkg::CFG_G11:      g11_q    <= cfg_data_i;
        olac_pkg::CFG_DT:       dt_q     <= cfg_data_i[30:0];
        olac_pkg::CFG_GEAR:     gear_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  olac_pkg::olac_state_e          state_q, state_d;
  logic [olac_pkg::UC_PC_W-1:0]   pc_q, pc_d;
  olac_pkg::uword_t               uw;
  logic                           in_fire, finish_fire, run, cstart;
  logic                           cos_valid_q;
  logic                           out_valid_q;

  assign uw  = olac_pkg::ucode(pc_q);
  assign run = (state_q == olac_pkg::ST_RUN);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      olac_pkg::ST_IDLE: if (in_valid_i) state_d = olac_pkg::ST_RUN;
      olac_pkg::ST_RUN:  if (finish_fire) state_d = olac_pkg::ST_IDLE;
      default:           state_d = olac_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs and step counter
  always_comb begin
    in_ready_o  = (state_q == olac_pkg::ST_IDLE);
    in_fire     = in_valid_i && in_ready_o;
    finish_fire = 1'b0;
    cstart      = 1'b0;
    pc_d        = pc_q;
    if (in_fire) begin
      pc_d = '0;
    end else if (run) begin
      case (uw.seq)
        olac_pkg::SEQ_NEXT: pc_d = pc_q + 1'b1;
        olac_pkg::SEQ_CORDIC_START: begin
          cstart = 1'b1;
          pc_d   = pc_q + 1'b1;
        end
        olac_pkg::SEQ_WAIT_COS: if (cos_valid_q) pc_d = pc_q + 1'b1;
        olac_pkg::SEQ_FINISH:   finish_fire = !out_valid_q || out_ready_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olac_pkg::ST_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Input latch and working registers
  olac_pkg::ctrl_in_t in_q;
  logic signed [31:0] e_q, de_q, a_q, r_q, t0_q, t1_q, f0_q, f1_q, s_q;
  logic signed [31:0] p0_q, p1_q;
  logic signed [31:0] cos_val;

  always_ff @(posedge clk_i) begin
    if (in_fire) in_q <= in_data_i;
  end

  // Operand select
  function automatic logic signed [31:0] src_val(input olac_pkg::src_e sel);
    logic signed [31:0] v;
    case (sel)
      olac_pkg::SRC_ANGLE:  v = in_q.angle;
      olac_pkg::SRC_RATE:   v = in_q.angle_rate;
      olac_pkg::SRC_TANGLE: v = in_q.target_angle;
      olac_pkg::SRC_TRATE:  v = in_q.target_rate;
      olac_pkg::SRC_TACCEL: v = in_q.target_accel;
      olac_pkg::SRC_INV2PI: v = olac_pkg::INV_TWO_PI_Q32;
      olac_pkg::SRC_LAMBDA: v = {1'b0, lambda_q};
      olac_pkg::SRC_KFB:    v = {1'b0, kfb_q};
      olac_pkg::SRC_G00:    v = g00_q;
      olac_pkg::SRC_G01:    v = g01_q;
      olac_pkg::SRC_G10:    v = g10_q;
      olac_pkg::SRC_G11:    v = g11_q;
      olac_pkg::SRC_DT:     v = {1'b0, dt_q};
      olac_pkg::SRC_GEAR:   v = gear_q;
      olac_pkg::SRC_E:      v = e_q;
      olac_pkg::SRC_DE:     v = de_q;
      olac_pkg::SRC_A:      v = a_q;
      olac_pkg::SRC_R:      v = r_q;
      olac_pkg::SRC_COS:    v = cos_val;
      olac_pkg::SRC_T0:     v = t0_q;
      olac_pkg::SRC_T1:     v = t1_q;
      olac_pkg::SRC_F0:     v = f0_q;
      olac_pkg::SRC_F1:     v = f1_q;
      olac_pkg::SRC_P0:     v = p0_q;
      olac_pkg::SRC_P1:     v = p1_q;
      olac_pkg::SRC_S:      v = s_q;
      default:              v = 32'sd0;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared multiplier, registered
  logic signed [31:0] mul_a, mul_b, acc_in;
  logic signed [63:0] mul_a64, mul_b64, prod_q;

  // Operands follow both the control word and the registers it selects
  always_comb begin
    mul_a  = src_val(uw.mul_a);
    mul_b  = src_val(uw.mul_b);
    acc_in = src_val(uw.acc_src);
  end

  assign mul_a64 = {{32{mul_a[31]}}, mul_a};
  assign mul_b64 = {{32{mul_b[31]}}, mul_b};

  always_ff @(posedge clk_i) begin
    if (run && uw.mul_en) prod_q <= mul_a64 * mul_b64;
  end

  // ---------------------------------------------------------------------------
  // Accumulator: scaled product (floor shift), exact or saturated
  logic signed [63:0]      prod_sh;
  logic signed [ACC_W-1:0] praw, psat, src_ext, acc_q, acc_d, wr_acc;
  logic signed [31:0]      psat32, wr_val;

  assign prod_sh = prod_q >>> FRAC_BITS;
  assign praw    = {{(ACC_W-64){prod_sh[63]}}, prod_sh};
  assign psat32  = olac_pkg::sat32(praw);
  assign psat    = {{(ACC_W-32){psat32[31]}}, psat32};
  assign src_ext = {{(ACC_W-32){acc_in[31]}}, acc_in};

  always_comb begin
    case (uw.acc_op)
      olac_pkg::ACC_LD_SRC:   acc_d = src_ext;
      olac_pkg::ACC_SUB_SRC:  acc_d = acc_q - src_ext;
      olac_pkg::ACC_LD_PSAT:  acc_d = psat;
      olac_pkg::ACC_ADD_PSAT: acc_d = acc_q + psat;
      olac_pkg::ACC_SUB_PSAT: acc_d = acc_q - psat;
      olac_pkg::ACC_LD_PRAW:  acc_d = praw;
      olac_pkg::ACC_ADD_PRAW: acc_d = acc_q + praw;
      default:                acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (run) acc_q <= acc_d;
  end

  // Register writeback, saturated, optionally negated
  assign wr_acc = uw.wr_neg ? -acc_q : acc_q;
  assign wr_val = olac_pkg::sat32(wr_acc);

  always_ff @(posedge clk_i) begin
    if (run) begin
      case (uw.dst)
        olac_pkg::DST_E:  e_q  <= wr_val;
        olac_pkg::DST_DE: de_q <= wr_val;
        olac_pkg::DST_A:  a_q  <= wr_val;
        olac_pkg::DST_R:  r_q  <= wr_val;
        olac_pkg::DST_T0: t0_q <= wr_val;
        olac_pkg::DST_T1: t1_q <= wr_val;
        olac_pkg::DST_F0: f0_q <= wr_val;
        olac_pkg::DST_F1: f1_q <= wr_val;
        olac_pkg::DST_S:  s_q  <= wr_val;
        default: ;
      endcase
    end
  end

  // Parameter estimates, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_q <= 32'sd0;
      p1_q <= 32'sd0;
    end else if (run) begin
      if (uw.dst == olac_pkg::DST_P0) p0_q <= wr_val;
      if (uw.dst == olac_pkg::DST_P1) p1_q <= wr_val;
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC cosine, one rotation per cycle
  logic [31:0]                        turn;
  logic signed [31:0]                 turn_s, z_start;
  logic                               flip_start;
  logic signed [CW-1:0]               cx_q, cy_q, cz_q, dx, dy, atan_ext;
  logic signed [CW-1:0]               cos_sh, cos_sgn;
  logic [olac_pkg::CORDIC_ITER_W-1:0] citer_q;
  logic                               cbusy_q, cflip_q;

  // Phase: angle/(2*pi) as a turn fraction, quantized to the table resolution
  assign turn       = prod_q[FRAC_BITS+31:FRAC_BITS] & PHASE_MASK;
  assign turn_s     = turn;
  assign flip_start = (turn_s > 32'sh40000000) || (turn_s < -32'sh40000000);
  // Half-turn move toggles the top bit of the phase
  assign z_start    = flip_start ? {~turn[31], turn[30:0]} : turn_s;

  assign dx       = cy_q >>> citer_q;
  assign dy       = cx_q >>> citer_q;
  assign atan_ext = {{(CW-32){1'b0}}, olac_pkg::atan_turn(citer_q)};

  always_ff @(posedge clk_i) begin
    if (cstart) begin
      cx_q    <= olac_pkg::CORDIC_START;
      cy_q    <= '0;
      cz_q    <= {{(CW-32){z_start[31]}}, z_start};
      cflip_q <= flip_start;
    end else if (cbusy_q) begin
      if (!cz_q[CW-1]) begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        cz_q <= cz_q - atan_ext;
      end else begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        cz_q <= cz_q + atan_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cbusy_q     <= 1'b0;
      cos_valid_q <= 1'b0;
      citer_q     <= '0;
    end else if (cstart) begin
      cbusy_q     <= 1'b1;
      cos_valid_q <= 1'b0;
      citer_q     <= '0;
    end else if (cbusy_q) begin
      if (citer_q == olac_pkg::CORDIC_ITER_W'(olac_pkg::CORDIC_STEPS - 1)) begin
        cbusy_q     <= 1'b0;
        cos_valid_q <= 1'b1;
      end
      citer_q <= citer_q + 1'b1;
    end
  end

  // Scale Q4.30 to the output format, undo the half-turn move
  assign cos_sh  = cx_q >>> (30 - FRAC_BITS);
  assign cos_sgn = cflip_q ? -cos_sh : cos_sh;
  assign cos_val = olac_pkg::sat32({{(ACC_W-CW){cos_sgn[CW-1]}}, cos_sgn});

  // ---------------------------------------------------------------------------
  // Output register
  olac_pkg::ctrl_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_fire) begin
      out_q.torque           <= olac_pkg::sat32(acc_q);
      out_q.angle_error      <= e_q;
      out_q.rate_error       <= de_q;
      out_q.estimate_inertia <= p0_q;
      out_q.estimate_gravity <= p1_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run |-> (pc_q <= olac_pkg::UC_LAST))
    else $error("step counter beyond end of program");

  a_cos_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run && uw.seq == olac_pkg::SEQ_WAIT_COS && cos_valid_q) |-> !cbusy_q)
    else $error("cosine taken while CORDIC still iterating");

  a_finish_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run && uw.seq == olac_pkg::SEQ_FINISH && out_valid_q && !out_ready_i)
      |=> (run && pc_q == $past(pc_q)))
    else $error("result dropped while output register occupied");

  a_cordic_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cbusy_q |-> (citer_q < olac_pkg::CORDIC_ITER_W'(olac_pkg::CORDIC_STEPS)))
    else $error("CORDIC iteration count overrun");

endmodule

/* verif/tb_one_link_adaptive_controller.sv */
// Self-checking testbench for one_link_adaptive_controller (single-link adaptive control tick).
// A bit-exact fixed-point predictor checks every result item; stimulus, gains and stalls vary.
// Depends on olac_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_one_link_adaptive_controller;

  localparam int FRAC = 16;
  localparam int COS_BITS = 10;
  localparam int REG_COUNT = int'(olac_pkg::CFG_GEAR) + 1;
  localparam int PHASES = 10;
  localparam int DRAIN_CYCLES = 64;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;
  localparam logic signed [31:0] HALF_PI = 32'sh0001921F;
  localparam logic signed [31:0] PI_Q = 32'sh0003243F;
  localparam logic signed [31:0] TWO_PI = 32'sh0006487F;
  localparam logic [31:0] DEF_DT = 32'd66;

  // Cosine constants: radians to turns, and the gain-compensated CORDIC seed
  localparam longint TURN_PER_RAD = 64'sd683565276;
  localparam longint CORDIC_SEED = 64'sd652032874;
  localparam int ROT_STEPS = 24;
  localparam logic [31:0] TURN_ATAN [ROT_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // How a directed row gets its expectation
  typedef enum logic [1:0] {
    FROM_MODEL,
    TYPED_ALL,
    TYPED_ERRS
  } row_check_e;

  typedef struct packed {
    olac_pkg::ctrl_in_t  stim;
    row_check_e          how;
    olac_pkg::ctrl_out_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 17;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // zero state, zero input: everything stays zero
    '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, TYPED_ALL, '0},
    '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, TYPED_ALL, '0},
    // saturating error terms
    '{'{Q_MAX, Q_MIN, Q_MIN, Q_MAX, 32'sd0}, TYPED_ERRS, '{32'sd0, Q_MAX, Q_MIN, 32'sd0, 32'sd0}},
    '{'{Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX}, TYPED_ERRS, '{32'sd0, Q_MIN, Q_MAX, 32'sd0, 32'sd0}},
    '{'{Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN}, TYPED_ERRS, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}},
    '{'{Q_MAX, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, TYPED_ERRS, '{32'sd0, Q_MAX, 32'sd0, 32'sd0, 32'sd0}},
    '{'{32'sd0, 32'sd0, Q_MAX, Q_MIN, Q_MAX}, TYPED_ERRS,
      '{32'sd0, 32'sh80000001, Q_MAX, 32'sd0, 32'sd0}},
    // cosine quadrants, half-turn fold and phase wrap
    '{'{HALF_PI, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, FROM_MODEL, '0},
    '{'{-HALF_PI, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, FROM_MODEL, '0},
    '{'{PI_Q, 32'sd0, 32'sd0, 32'sd0, ONE}, FROM_MODEL, '0},
    '{'{-PI_Q, ONE, 32'sd0, 32'sd0, 32'sd0}, FROM_MODEL, '0},
    '{'{TWO_PI, 32'sd0, ONE, 32'sd0, 32'sd0}, FROM_MODEL, '0},
    '{'{32'sh00025B2F, -ONE, 32'sd0, ONE, 32'sd0}, FROM_MODEL, '0},
    '{'{32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sd0}, FROM_MODEL, '0},
    '{'{-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1}, FROM_MODEL, '0},
    '{'{32'sh00008000, ONE, 32'sd0, 32'sd0, ONE}, FROM_MODEL, '0},
    '{'{ONE, -ONE, -ONE, ONE, 32'sh00020000}, FROM_MODEL, '0}
  };

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  olac_pkg::ctrl_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  olac_pkg::ctrl_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [olac_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Predictor state: gain registers and parameter estimates
  logic [31:0] gain_reg [REG_COUNT];
  int est_inertia;
  int est_gravity;

  olac_pkg::ctrl_out_t pending_results[$];
  int mismatch_count = 0;
  bit tx_idle_on;
  bit rx_stall_on;

  one_link_adaptive_controller #(
    .FRAC_BITS(FRAC),
    .COS_TABLE_BITS(COS_BITS)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o(out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return int'(Q_MAX);
    end else if (v < -64'sd2147483648) begin
      return int'(Q_MIN);
    end
    return int'(v[31:0]);
  endfunction

  // Exact product scaled down, floor rounding (arithmetic shift)
  function automatic longint mul_floor(int x, int y);
    longint p;
    p = longint'(x) * longint'(y);
    return p >>> FRAC;
  endfunction

  function automatic int mul_sat(int x, int y);
    return clamp32(mul_floor(x, y));
  endfunction

  // Cosine: angle to turn phase, table truncation, half-turn fold, rotation CORDIC
  function automatic int cos_fx(int ang);
    longint ph;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    logic [31:0] turn;
    bit flip;
    ph = (longint'(ang) * TURN_PER_RAD) >>> FRAC;
    turn = ph[31:0];
    turn = turn & (32'hFFFFFFFF << (32 - COS_BITS));
    z = longint'(int'(turn));
    flip = 1'b0;
    if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
      flip = 1'b1;
      z = longint'(int'(turn - 32'h80000000));
    end
    x = CORDIC_SEED;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(TURN_ATAN[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(TURN_ATAN[i]);
      end
    end
    x = x >>> (30 - FRAC);
    if (flip) begin
      x = -x;
    end
    return clamp32(x);
  endfunction

  // One control tick: errors, sliding variable, estimate update, torque
  function automatic olac_pkg::ctrl_out_t predict_control(olac_pkg::ctrl_in_t d);
    int lam, kfb, g00, g01, g10, g11, dt, gear;
    int e, de, a, r, c, t0, t1, f0, f1, p0, p1, s;
    olac_pkg::ctrl_out_t o;
    lam = int'(gain_reg[olac_pkg::CFG_LAMBDA]);
    kfb = int'(gain_reg[olac_pkg::CFG_FEEDBACK]);
    g00 = int'(gain_reg[olac_pkg::CFG_G00]);
    g01 = int'(gain_reg[olac_pkg::CFG_G01]);
    g10 = int'(gain_reg[olac_pkg::CFG_G10]);
    g11 = int'(gain_reg[olac_pkg::CFG_G11]);
    dt = int'(gain_reg[olac_pkg::CFG_DT]);
    gear = int'(gain_reg[olac_pkg::CFG_GEAR]);

    e = clamp32(longint'(d.angle) - longint'(d.target_angle));
    de = clamp32(longint'(d.angle_rate) - longint'(d.target_rate));
    a = clamp32(longint'(d.target_accel) - longint'(mul_sat(lam, de)));
    r = clamp32(longint'(de) + longint'(mul_sat(lam, e)));
    c = cos_fx(d.angle);

    t0 = mul_sat(a, r);
    t1 = mul_sat(c, r);
    f0 = clamp32(-(mul_floor(g00, t0) + mul_floor(g01, t1)));
    f1 = clamp32(-(mul_floor(g10, t0) + mul_floor(g11, t1)));
    p0 = clamp32(longint'(est_inertia) + longint'(mul_sat(f0, dt)));
    p1 = clamp32(longint'(est_gravity) + longint'(mul_sat(f1, dt)));
    est_inertia = p0;
    est_gravity = p1;

    s = clamp32(mul_floor(a, p0) + mul_floor(c, p1) + mul_floor(kfb, r));

    o.torque = mul_sat(gear, s);
    o.angle_error = e;
    o.rate_error = de;
    o.estimate_inertia = p0;
    o.estimate_gravity = p1;
    return o;
  endfunction

  function automatic logic [31:0] gain_mask(logic [olac_pkg::CFG_IDX_W-1:0] idx);
    case (idx)
      olac_pkg::CFG_LAMBDA, olac_pkg::CFG_FEEDBACK, olac_pkg::CFG_DT: return 32'h7FFFFFFF;
      default: return 32'hFFFFFFFF;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  // Idle length: mostly none, some short, a few long
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return 0;
    end else if (pick < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(12, 70);
  endfunction

  function automatic int near(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int edge_value();
    case ($urandom_range(0, 4))
      0: return int'(Q_MAX);
      1: return int'(Q_MIN);
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic int mixed_value();
    if ($urandom_range(0, 1) == 1) begin
      return int'($urandom);
    end
    return near(32'h40000);
  endfunction

  // Mostly plausible trajectories near the target, then full range and edge values
  function automatic olac_pkg::ctrl_in_t random_tick();
    olac_pkg::ctrl_in_t d;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      d.angle = near(32'h60000);
      d.target_angle = d.angle + near(32'h10000);
      d.angle_rate = near(32'h50000);
      d.target_rate = d.angle_rate + near(32'h8000);
      d.target_accel = near(32'h100000);
    end else if (kind <= 7) begin
      d = {$urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (kind == 8) begin
      d.angle = edge_value();
      d.angle_rate = edge_value();
      d.target_angle = edge_value();
      d.target_rate = edge_value();
      d.target_accel = edge_value();
    end else begin
      d.angle = mixed_value();
      d.angle_rate = mixed_value();
      d.target_angle = mixed_value();
      d.target_rate = mixed_value();
      d.target_accel = mixed_value();
    end
    return d;
  endfunction

  // Send one tick item, then queue its expected result
  task automatic send_tick(olac_pkg::ctrl_in_t stim, row_check_e how,
                           olac_pkg::ctrl_out_t want);
    int gap;
    olac_pkg::ctrl_out_t model;
    gap = tx_idle_on ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = stim;
    do @(posedge clk); while (!in_ready);
    model = predict_control(stim);
    if (how == TYPED_ALL) begin
      model = want;
    end else if (how == TYPED_ERRS) begin
      model.angle_error = want.angle_error;
      model.rate_error = want.rate_error;
    end
    pending_results.push_back(model);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_gain(logic [olac_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= olac_pkg::CFG_GEAR) begin
      gain_reg[idx] = val & gain_mask(idx);
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Full register set, with a write to an unmapped index mixed in
  task automatic program_gains(logic [31:0] lam, logic [31:0] kfb, logic [31:0] g00,
                               logic [31:0] g01, logic [31:0] g10, logic [31:0] g11,
                               logic [31:0] dt, logic [31:0] gear);
    logic [olac_pkg::CFG_IDX_W-1:0] stray;
    stray = olac_pkg::CFG_IDX_W'($urandom_range(REG_COUNT, 15));
    write_gain(olac_pkg::CFG_LAMBDA, lam);
    write_gain(olac_pkg::CFG_FEEDBACK, kfb);
    write_gain(olac_pkg::CFG_G00, g00);
    write_gain(olac_pkg::CFG_G01, g01);
    write_gain(stray, $urandom);
    write_gain(olac_pkg::CFG_G10, g10);
    write_gain(olac_pkg::CFG_G11, g11);
    write_gain(olac_pkg::CFG_DT, dt);
    write_gain(olac_pkg::CFG_GEAR, gear);
  endtask

  task automatic set_phase_gains(int p);
    case (p)
      // extremes; bit 31 on the narrow registers must be dropped
      1: program_gains(32'hFFFFFFFF, 32'hFFFFFFFF, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                       32'hFFFFFFFF, Q_MAX);
      2: program_gains(32'h0, 32'h0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 32'h0, Q_MIN);
      3: program_gains(32'h7FFFFFFF, 32'h80000000, Q_MIN, Q_MAX, Q_MAX, Q_MIN,
                       32'h7FFFFFFF, -32'sd1);
      4: program_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
      PHASES - 1: program_gains(ONE, ONE, ONE, 32'h0, 32'h0, ONE, DEF_DT, ONE);
      default: program_gains($urandom_range(0, 32'h80000), $urandom_range(0, 32'h80000),
                             near(32'h40000), near(32'h8000), near(32'h8000),
                             near(32'h40000), $urandom_range(0, 32'h1000),
                             near(32'h20000));
    endcase
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin : ready_gen
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        hold = rx_stall_on ? idle_len() : 0;
      end
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checker

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      mismatch_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    olac_pkg::ctrl_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $error("result item arrived with no expectation pending");
      end else begin
        want = pending_results.pop_front();
        check_field("torque", want.torque, out_data.torque);
        check_field("angle_error", want.angle_error, out_data.angle_error);
        check_field("rate_error", want.rate_error, out_data.rate_error);
        check_field("estimate_inertia", want.estimate_inertia, out_data.estimate_inertia);
        check_field("estimate_gravity", want.estimate_gravity, out_data.estimate_gravity);
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin : main_seq
    int n_items;
    gain_reg[olac_pkg::CFG_LAMBDA] = ONE;
    gain_reg[olac_pkg::CFG_FEEDBACK] = ONE;
    gain_reg[olac_pkg::CFG_G00] = ONE;
    gain_reg[olac_pkg::CFG_G01] = 32'h0;
    gain_reg[olac_pkg::CFG_G10] = 32'h0;
    gain_reg[olac_pkg::CFG_G11] = ONE;
    gain_reg[olac_pkg::CFG_DT] = DEF_DT;
    gain_reg[olac_pkg::CFG_GEAR] = ONE;
    est_inertia = 0;
    est_gravity = 0;
    tx_idle_on = 1'b1;
    rx_stall_on = 1'b1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      // one phase in four runs flat out, one stalls only the receiver
      tx_idle_on = (p % 4) < 2;
      rx_stall_on = (p % 4) != 2;
      if (p == 0) begin
        foreach (DIR_TABLE[i]) begin
          send_tick(DIR_TABLE[i].stim, DIR_TABLE[i].how, DIR_TABLE[i].want);
        end
      end else begin
        set_phase_gains(p);
      end
      if (p == 0) begin
        n_items = 90;
      end else if (p <= 3) begin
        n_items = 60;
      end else if (p == 4 || p == PHASES - 1) begin
        n_items = 150;
      end else begin
        n_items = 280;
      end
      for (int n = 0; n < n_items; n++) begin
        // hold the sender until the block has emptied
        if (n == n_items / 2) begin
          wait_drained();
        end
        send_tick(random_tick(), FROM_MODEL, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
